// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared definitions for the Q24.8 fixed-point ALU
// Operation codes, word width and the control bundle that travels along the
// divider chain together with each request.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int WORD_W            = 32;
    localparam int DEFAULT_FRAC_BITS = 8;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_GT       = 4'd4;
    localparam logic [3:0] OP_LT       = 4'd5;
    localparam logic [3:0] OP_GE       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_MIN      = 4'd10;
    localparam logic [3:0] OP_MAX      = 4'd11;
    localparam logic [3:0] OP_INC      = 4'd12;
    localparam logic [3:0] OP_DEC      = 4'd13;
    localparam logic [3:0] OP_FROM_INT = 4'd14;
    localparam logic [3:0] OP_TO_INT   = 4'd15;

    // Per-request control carried down the chain of divider cells.
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              cmp;
        logic              dz;
        logic [WORD_W-1:0] alt_value;
        logic [WORD_W-1:0] divisor;
    } ctl_t;

endpackage

// File: rtl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-division cell of the ALU pipeline
// Produces one quotient bit per request and hands the partial remainder, the
// shifting numerator/quotient word and the request's control on each cycle.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
    parameter int NUM_W = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    input  fpa_pkg::ctl_t              up_ctl,
    input  logic [fpa_pkg::WORD_W-1:0] up_rem,
    input  logic [NUM_W-1:0]           up_nq,
    output logic                       dn_valid,
    output fpa_pkg::ctl_t              dn_ctl,
    output logic [fpa_pkg::WORD_W-1:0] dn_rem,
    output logic [NUM_W-1:0]           dn_nq
);
    import fpa_pkg::*;

    logic              valid_reg;
    ctl_t              ctl_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [NUM_W-1:0]  nq_reg;

    logic [WORD_W:0]   trial;
    logic [WORD_W+1:0] diff;
    logic              fits;
    logic [WORD_W-1:0] rem_next;
    logic [NUM_W-1:0]  nq_next;

    // Bring down the next numerator bit and try to take the divisor away.
    assign trial    = {up_rem, up_nq[NUM_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, up_ctl.divisor};
    assign fits     = !diff[WORD_W+1];
    assign rem_next = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    assign nq_next  = {up_nq[NUM_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= up_ctl;
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_nq    = nq_reg;

`ifndef SYNTH
    // A division request keeps its partial remainder below a non-zero divisor.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ctl.is_div && (up_ctl.divisor != '0)
            && (up_rem < up_ctl.divisor)
        |=> (rem_reg < ctl_reg.divisor))
        else $error("partial remainder reached the divisor");
`endif

endmodule

// File: rtl/fixed_point_alu_q24_8_top.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_top: signed 32-bit fixed-point ALU
// Latency: the same for every operation; each request passes the front stage,
// the divider chain and the output register.
// Throughput: one request per cycle; busy never rises and the receiver cannot
// stall, so results leave in request order, one strobe per request.
// The latency is set by the divider chain: one cell per quotient bit.
// Reset (rst_n, asynchronous, active low) empties the pipeline at once.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_top #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [3:0]                        req_type,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
    output logic                              done,
    output logic signed [fpa_pkg::WORD_W-1:0] value_out,
    output logic                              compare_true,
    output logic                              divide_by_zero
);
    import fpa_pkg::*;

    // The numerator of a division is |a| scaled by 2^FRAC_BITS, so the
    // quotient magnitude needs WORD_W + FRAC_BITS bits before it is wrapped.
    localparam int NUM_W   = WORD_W + FRAC_BITS;
    localparam int LATENCY = NUM_W + 2;

    // ------------------------------------------------------------------
    // Front stage: decode the request. Everything except division is
    // finished here, including the single 32x32 multiplication; the
    // answer then rides along the divider chain so that all requests
    // keep the same latency and leave in order.
    // ------------------------------------------------------------------
    logic                      accept;
    logic signed [2*WORD_W-1:0] product;
    logic [WORD_W-1:0]         a_mag;
    logic [WORD_W-1:0]         b_mag;
    ctl_t                      front_ctl;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign product = operand_a * operand_b;
    assign a_mag   = operand_a[WORD_W-1] ? WORD_W'(-operand_a) : WORD_W'(operand_a);
    assign b_mag   = operand_b[WORD_W-1] ? WORD_W'(-operand_b) : WORD_W'(operand_b);

    always_comb
    begin
        front_ctl           = '0;
        front_ctl.divisor   = b_mag;
        front_ctl.neg       = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
        unique case (req_type)
            OP_ADD:      front_ctl.alt_value = operand_a + operand_b;
            OP_SUB:      front_ctl.alt_value = operand_a - operand_b;
            OP_MUL:      front_ctl.alt_value = product[FRAC_BITS +: WORD_W];
            OP_DIV:
            begin
                front_ctl.is_div = 1'b1;
                front_ctl.dz     = (operand_b == '0);
            end
            OP_GT:       front_ctl.cmp = (operand_a > operand_b);
            OP_LT:       front_ctl.cmp = (operand_a < operand_b);
            OP_GE:       front_ctl.cmp = (operand_a >= operand_b);
            OP_LE:       front_ctl.cmp = (operand_a <= operand_b);
            OP_EQ:       front_ctl.cmp = (operand_a == operand_b);
            OP_NE:       front_ctl.cmp = (operand_a != operand_b);
            OP_MIN:      front_ctl.alt_value = (operand_a < operand_b) ? operand_a : operand_b;
            OP_MAX:      front_ctl.alt_value = (operand_a > operand_b) ? operand_a : operand_b;
            OP_INC:      front_ctl.alt_value = operand_a + WORD_W'(1);
            OP_DEC:      front_ctl.alt_value = operand_a - WORD_W'(1);
            OP_FROM_INT: front_ctl.alt_value = operand_a <<< FRAC_BITS;
            OP_TO_INT:   front_ctl.alt_value = operand_a >>> FRAC_BITS;
            default:     front_ctl.alt_value = '0;
        endcase
    end

    logic             s0_valid_reg;
    ctl_t             s0_ctl_reg;
    logic [NUM_W-1:0] s0_nq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_ctl_reg <= front_ctl;
        s0_nq_reg  <= NUM_W'(a_mag) << FRAC_BITS;
    end

    // ------------------------------------------------------------------
    // Divider chain: NUM_W identical cells, one quotient bit each. The
    // numerator leaves the top of the nq word as quotient bits enter at
    // the bottom, so after the last cell nq holds the quotient magnitude.
    // ------------------------------------------------------------------
    logic              chain_valid [0:NUM_W];
    ctl_t              chain_ctl   [0:NUM_W];
    logic [WORD_W-1:0] chain_rem   [0:NUM_W];
    logic [NUM_W-1:0]  chain_nq    [0:NUM_W];

    assign chain_valid[0] = s0_valid_reg;
    assign chain_ctl[0]   = s0_ctl_reg;
    assign chain_rem[0]   = '0;
    assign chain_nq[0]    = s0_nq_reg;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        fpa_div_cell #(
            .NUM_W (NUM_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ctl   (chain_ctl[i]),
            .up_rem   (chain_rem[i]),
            .up_nq    (chain_nq[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ctl   (chain_ctl[i+1]),
            .dn_rem   (chain_rem[i+1]),
            .dn_nq    (chain_nq[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: apply the quotient sign, which also truncates toward
    // zero, wrap to 32 bits and pick the answer for the request's kind.
    // Division by zero gives a zero value with the flag set.
    // ------------------------------------------------------------------
    ctl_t              last_ctl;
    logic [WORD_W-1:0] quot_mag;
    logic [WORD_W-1:0] quot_val;
    logic [WORD_W-1:0] value_next;

    logic              done_reg;
    logic [WORD_W-1:0] value_reg;
    logic              cmp_reg;
    logic              dz_reg;

    assign last_ctl = chain_ctl[NUM_W];
    assign quot_mag = chain_nq[NUM_W][WORD_W-1:0];
    assign quot_val = last_ctl.neg ? (~quot_mag + WORD_W'(1)) : quot_mag;

    always_comb
    begin
        priority if (last_ctl.is_div && last_ctl.dz)
        begin
            value_next = '0;
        end
        else if (last_ctl.is_div)
        begin
            value_next = quot_val;
        end
        else
        begin
            value_next = last_ctl.alt_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        cmp_reg   <= last_ctl.cmp;
        dz_reg    <= last_ctl.dz;
    end

    assign done           = done_reg;
    assign value_out      = value_reg;
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

`ifndef SYNTH
    // Every accepted request leaves the pipeline as a result strobe.
    a_request_emerges: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted request did not produce a result");

    // No strobe appears without a request that went in earlier.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##LATENCY !done)
        else $error("result strobe without a request");

    // A divide-by-zero result carries zero and no comparison outcome.
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> (value_out == '0) && !compare_true)
        else $error("divide-by-zero result is not clean");
`endif

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Q24.8 fixed-point ALU
// Sends a short table of hand-picked requests and then several hundred random
// ones, in bursts with random gaps, and compares every strobed result field by
// field with the table's hand-typed values or an in-bench model of the arithmetic.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    // The bench is built for the default Q24.8 format. The pipeline depth
    // follows from the fraction width through the length of the divider chain.
    localparam int FRAC_BITS      = DEFAULT_FRAC_BITS;
    localparam int RESULT_LATENCY = FRAC_BITS + 34;
    localparam int RANDOM_COUNT   = 500;
    // Even with every request followed by the longest gap, 525 requests finish
    // far inside this limit, so it leaves a wide margin.
    localparam int CYCLE_LIMIT    = 100000;

    // One result as the receiver sees it.
    typedef struct {
        logic signed [WORD_W-1:0] value;
        logic                     cmp;
        logic                     dz;
    } alu_result_t;

    // One row of the directed table. Where "known" is set, the expected
    // result is typed in by hand; otherwise it comes from the model below.
    typedef struct {
        logic [3:0]        op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        bit                known;
        logic [WORD_W-1:0] value;
        logic              cmp;
        logic              dz;
    } stim_row_t;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     start          = 1'b0;
    logic [3:0]               req_type       = OP_ADD;
    logic signed [WORD_W-1:0] operand_a      = '0;
    logic signed [WORD_W-1:0] operand_b      = '0;
    logic                     busy;
    logic                     done;
    logic signed [WORD_W-1:0] value_out;
    logic                     compare_true;
    logic                     divide_by_zero;

    // Results still owed by the block, oldest first.
    alu_result_t pending_results[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;

    // Directed requests: the wrap-around corners of add, subtract, increment
    // and decrement, the sign handling of multiply and divide, division by
    // zero and the overflowing quotient of the most negative value by minus
    // one, all six comparisons, some across the extremes, min (also with equal
    // operands) and max, and both conversions with their wrap and floor cases.
    // Operand B of the single-operand operations is deliberately non-zero to
    // show that it is ignored.
    stim_row_t directed_rows [25] = '{
        '{OP_ADD,      32'h7fff_ffff, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
        '{OP_ADD,      32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_fffe, 1'b0, 1'b0},
        '{OP_SUB,      32'h8000_0000, 32'h0000_0001, 1'b1, 32'h7fff_ffff, 1'b0, 1'b0},
        '{OP_MUL,      32'h0000_0100, 32'h0000_0100, 1'b1, 32'h0000_0100, 1'b0, 1'b0},
        '{OP_MUL,      32'hffff_ffff, 32'h0000_0001, 1'b0, '0,            1'b0, 1'b0},
        '{OP_MUL,      32'h8000_0000, 32'h8000_0000, 1'b0, '0,            1'b0, 1'b0},
        '{OP_DIV,      32'h0000_0100, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1},
        '{OP_DIV,      32'h8000_0000, 32'hffff_ffff, 1'b0, '0,            1'b0, 1'b0},
        '{OP_DIV,      32'hffff_fd00, 32'h0000_0200, 1'b0, '0,            1'b0, 1'b0},
        '{OP_DIV,      32'hffff_ffff, 32'hffff_ffff, 1'b0, '0,            1'b0, 1'b0},
        '{OP_GT,       32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{OP_LT,       32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{OP_GE,       32'h0000_0005, 32'h0000_0005, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{OP_LE,       32'h0000_0006, 32'h0000_0005, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{OP_EQ,       32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{OP_NE,       32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{OP_MIN,      32'h1234_5678, 32'h1234_5678, 1'b0, '0,            1'b0, 1'b0},
        '{OP_MIN,      32'hffff_ffff, 32'h0000_0001, 1'b0, '0,            1'b0, 1'b0},
        '{OP_MAX,      32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0, 1'b0},
        '{OP_INC,      32'h7fff_ffff, 32'hffff_ffff, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
        '{OP_DEC,      32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h7fff_ffff, 1'b0, 1'b0},
        '{OP_FROM_INT, 32'h0000_0001, 32'h5555_5555, 1'b1, 32'h0000_0100, 1'b0, 1'b0},
        '{OP_FROM_INT, 32'h7fff_ffff, 32'haaaa_aaaa, 1'b0, '0,            1'b0, 1'b0},
        '{OP_TO_INT,   32'hffff_ffff, 32'h0000_0001, 1'b1, 32'hffff_ffff, 1'b0, 1'b0},
        '{OP_TO_INT,   32'h8000_0000, 32'h7fff_ffff, 1'b0, '0,            1'b0, 1'b0}
    };

    fixed_point_alu_q24_8_top #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .done          (done),
        .value_out     (value_out),
        .compare_true  (compare_true),
        .divide_by_zero(divide_by_zero)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Computes the result that one request must produce. Products and scaled
    // dividends are formed at 64 bits, so nothing overflows before the final
    // wrap back to the word width.
    function automatic alu_result_t fixed_point_result(
        input logic [3:0]               op,
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        alu_result_t r;
        longint      wide;
        r.value = '0;
        r.cmp   = 1'b0;
        r.dz    = 1'b0;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL:
            begin
                // The arithmetic shift floors, so negative products round down.
                wide    = longint'(a) * longint'(b);
                wide    = wide >>> FRAC_BITS;
                r.value = wide[WORD_W-1:0];
            end
            OP_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    // Signed division truncates toward zero.
                    wide    = longint'(a) <<< FRAC_BITS;
                    wide    = wide / longint'(b);
                    r.value = wide[WORD_W-1:0];
                end
            end
            OP_GT:       r.cmp   = (a > b);
            OP_LT:       r.cmp   = (a < b);
            OP_GE:       r.cmp   = (a >= b);
            OP_LE:       r.cmp   = (a <= b);
            OP_EQ:       r.cmp   = (a == b);
            OP_NE:       r.cmp   = (a != b);
            OP_MIN:      r.value = (a < b) ? a : b;
            OP_MAX:      r.value = (a > b) ? a : b;
            OP_INC:      r.value = a + 32'sd1;
            OP_DEC:      r.value = a - 32'sd1;
            OP_FROM_INT: r.value = a <<< FRAC_BITS;
            OP_TO_INT:   r.value = a >>> FRAC_BITS;
        endcase
        return r;
    endfunction

    // Operands are drawn from a mix of full-width random words, values of
    // modest size around zero (where fixed-point results stay readable and
    // comparisons are often close) and the corner values.
    function automatic logic signed [WORD_W-1:0] random_operand();
        logic signed [WORD_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = WORD_W'($urandom_range(0, 32'h1_ffff)) - 32'sh1_0000;
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       v = 32'sh0000_0000;
                    1:       v = 32'sh0000_0001;
                    2:       v = -32'sh0000_0001;
                    3:       v = 32'sh7fff_ffff;
                    4:       v = 32'sh8000_0000;
                    5:       v = 32'sh0000_0100;
                    default: v = -32'sh0000_0100;
                endcase
            end
        endcase
        return v;
    endfunction

    // Presents one request and holds it until the block takes it. Called at
    // a rising edge; returns at the edge that accepted the request, which is
    // also when its expected result joins the queue.
    task automatic issue_request(
        input logic [3:0]               op,
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b,
        input alu_result_t              want
    );
        start     <= 1'b1;
        req_type  <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(want);
    endtask

    // The sender works in bursts. When a burst runs out, start drops for a
    // random number of cycles (sometimes none, so bursts merge), and the next
    // burst length is chosen; now and then a long burst keeps the pipeline
    // completely full for a good stretch.
    task automatic pace_sender();
        int gap;
        burst_left = burst_left - 1;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stimulus: reset, the directed table, then the random requests, and at
    // the end a drain of everything still in flight.
    initial
    begin
        alu_result_t              want;
        logic [3:0]               op;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
            begin
                want.value = directed_rows[i].value;
                want.cmp   = directed_rows[i].cmp;
                want.dz    = directed_rows[i].dz;
            end
            else
            begin
                want = fixed_point_result(directed_rows[i].op, directed_rows[i].a,
                                          directed_rows[i].b);
            end
            issue_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b, want);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            op = 4'($urandom_range(0, 15));
            a  = random_operand();
            b  = random_operand();
            // Equal operands exercise the boundary of every comparison and the
            // tie rule of min and max; a forced zero divisor makes division by
            // zero turn up regularly.
            if ($urandom_range(0, 7) == 0)
                b = a;
            if (op == OP_DIV && $urandom_range(0, 7) == 0)
                b = '0;
            issue_request(op, a, b, fixed_point_result(op, a, b));
            pace_sender();
        end
        start <= 1'b0;

        // Wait for the last result, then listen a while longer for any stray
        // strobe that nothing asked for.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 8) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result checker. The outputs are sampled at the rising edge, so the
    // values seen are those of the cycle that the edge ends, which is exactly
    // the cycle in which the strobe marks a result.
    always @(posedge clk)
    begin : result_check
        alu_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding: value %h cmp %b dz %b",
                         $time, value_out, compare_true, divide_by_zero);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (value_out !== want.value)
                begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, want.value, value_out);
                    mismatches++;
                end
                if (compare_true !== want.cmp)
                begin
                    $display("%0t: compare_true expected %b actual %b",
                             $time, want.cmp, compare_true);
                    mismatches++;
                end
                if (divide_by_zero !== want.dz)
                begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, want.dz, divide_by_zero);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/fpa_pkg.sv
rtl/fpa_div_cell.sv
rtl/fixed_point_alu_q24_8_top.sv
verif/testbench.sv
